>>> rtl/pdtd_pkg.sv
package pdtd_pkg;

    localparam int PAD_COUNT = 4;
    localparam int PAD_W     = 2;
    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 32;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CURVE_IDX_W = 7;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd600;
    localparam logic [TIME_W-1:0]   HOLDOFF_RST   = 32'd22730;
    localparam logic [NOTE_W-1:0]   NOTE_RST [PAD_COUNT] = '{7'd51, 7'd50, 7'd52, 7'd53};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_HOLDOFF   = 3'd1,
        REG_NOTE_0    = 3'd2,
        REG_NOTE_1    = 3'd3,
        REG_NOTE_2    = 3'd4,
        REG_NOTE_3    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [PAD_W-1:0]  event_pad;
        logic              is_note_on;
        logic [NOTE_W-1:0] note_number;
        logic [VEL_W-1:0]  note_velocity;
    } result_t;

    // v * (ln(v+1) + v/5), floored, saturated at 127
    function automatic logic [VEL_W-1:0] vel_curve(input logic [CURVE_IDX_W-1:0] idx);
        logic [VEL_W-1:0] v;
        begin
            case (idx)
                7'd0:    v = 7'd0;
                7'd1:    v = 7'd0;
                7'd2:    v = 7'd2;
                7'd3:    v = 7'd5;
                7'd4:    v = 7'd9;
                7'd5:    v = 7'd13;
                7'd6:    v = 7'd18;
                7'd7:    v = 7'd24;
                7'd8:    v = 7'd30;
                7'd9:    v = 7'd36;
                7'd10:   v = 7'd43;
                7'd11:   v = 7'd51;
                7'd12:   v = 7'd59;
                7'd13:   v = 7'd68;
                7'd14:   v = 7'd77;
                7'd15:   v = 7'd86;
                7'd16:   v = 7'd96;
                7'd17:   v = 7'd106;
                7'd18:   v = 7'd117;
                default: v = 7'd127;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/pdtd_in_if.sv
interface pdtd_in_if
    import pdtd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [PAD_W-1:0]    pad_index;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   time_us;

    modport source (output valid, output pad_index, output sample, output time_us,
                    input ready);
    modport sink (input valid, input pad_index, input sample, input time_us,
                  output ready);
endinterface

>>> rtl/pdtd_out_if.sv
interface pdtd_out_if
    import pdtd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PAD_W-1:0]  event_pad;
    logic              is_note_on;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;

    modport source (output valid, output event_pad, output is_note_on,
                    output note_number, output note_velocity, input ready);
    modport sink (input valid, input event_pad, input is_note_on,
                  input note_number, input note_velocity, output ready);
endinterface

>>> rtl/piezo_drum_trigger_detector_top.sv
// A note event is registered in the head entry, or in the skid if head stalls.
// Throughput: one sample per cycle while the skid is empty; pad state is read and
// updated in the cycle of the transfer, and a two-entry output register (head plus
// skid) keeps input running while a result waits.
// Reset (rst_n, async, active low): pad state cleared, registers to defaults.
module piezo_drum_trigger_detector_top
    import pdtd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pdtd_in_if.sink                in_ch,
    pdtd_out_if.source             out_ch
);

    logic [SAMPLE_W-1:0] threshold_reg;
    logic [TIME_W-1:0]   holdoff_reg;
    logic [NOTE_W-1:0]   note_pad_reg [PAD_COUNT];

    logic [SAMPLE_W-1:0] prev_sample_reg [PAD_COUNT];
    logic [PAD_COUNT-1:0] active_reg;
    logic [PAD_COUNT-1:0] before_reg;
    logic [PAD_COUNT-1:0] armed_reg;
    logic [TIME_W-1:0]   holdoff_start_reg [PAD_COUNT];
    logic [VEL_W-1:0]    held_vel_reg [PAD_COUNT];

    result_t head_reg, skid_reg;
    logic    head_valid_reg, skid_valid_reg;

    logic [PAD_W-1:0]    pad;
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] last;
    logic                pad_ok;
    logic                elapsed;
    logic                arm_hit, strike_hit, rel_hit, on_emit;
    logic                active_next, armed_next;
    logic [VEL_W-1:0]    vel_next;
    logic [CURVE_IDX_W-1:0] curve_idx;
    logic                in_fire, head_fire, res_valid;
    result_t             res;

    assign pad     = in_ch.pad_index;
    assign s       = in_ch.sample;
    assign pad_ok  = {1'b0, pad} < 3'(PAD_COUNT);
    assign last    = prev_sample_reg[pad];
    assign elapsed = (in_ch.time_us - holdoff_start_reg[pad]) >= holdoff_reg;

    assign curve_idx = (last[SAMPLE_W-1:3] == '0) ? '0 : last[SAMPLE_W-1:3] - 7'd1;

    always_comb
    begin
        arm_hit    = (s >= threshold_reg) && (s > last) && !active_reg[pad] && !armed_reg[pad];
        strike_hit = !arm_hit && (last > s) && (last > threshold_reg)
                     && !active_reg[pad] && armed_reg[pad];
        rel_hit    = !arm_hit && !strike_hit && (s < threshold_reg)
                     && active_reg[pad] && before_reg[pad] && elapsed;
        on_emit    = strike_hit && !before_reg[pad] && elapsed;
        vel_next   = strike_hit ? vel_curve(curve_idx) : held_vel_reg[pad];
        active_next = strike_hit ? 1'b1 : (rel_hit ? 1'b0 : active_reg[pad]);
        armed_next  = arm_hit ? 1'b1 : (rel_hit ? 1'b0 : armed_reg[pad]);
        res.event_pad     = pad;
        res.is_note_on    = on_emit;
        res.note_number   = note_pad_reg[pad];
        res.note_velocity = vel_next;
    end

    assign in_ch.ready = !skid_valid_reg;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign head_fire   = head_valid_reg && out_ch.ready;
    assign res_valid   = in_fire && pad_ok && (on_emit || rel_hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            holdoff_reg   <= HOLDOFF_RST;
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                note_pad_reg[i] <= NOTE_RST[i];
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg   <= cfg_data[SAMPLE_W-1:0];
                REG_HOLDOFF:   holdoff_reg     <= cfg_data[TIME_W-1:0];
                REG_NOTE_0:    note_pad_reg[0] <= cfg_data[NOTE_W-1:0];
                REG_NOTE_1:    note_pad_reg[1] <= cfg_data[NOTE_W-1:0];
                REG_NOTE_2:    note_pad_reg[2] <= cfg_data[NOTE_W-1:0];
                REG_NOTE_3:    note_pad_reg[3] <= cfg_data[NOTE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            before_reg <= '0;
            armed_reg  <= '0;
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                prev_sample_reg[i]   <= '0;
                holdoff_start_reg[i] <= '0;
                held_vel_reg[i]      <= '0;
            end
        end
        else if (in_fire && pad_ok)
        begin
            active_reg[pad]      <= active_next;
            before_reg[pad]      <= active_next;
            armed_reg[pad]       <= armed_next;
            prev_sample_reg[pad] <= s;
            held_vel_reg[pad]    <= vel_next;
            if (on_emit)
            begin
                holdoff_start_reg[pad] <= in_ch.time_us;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (head_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!head_valid_reg || head_fire)
        begin
            head_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (head_fire)
            begin
                head_reg <= skid_reg;
            end
        end
        else if (!head_valid_reg || head_fire)
        begin
            head_reg <= res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign out_ch.valid         = head_valid_reg;
    assign out_ch.event_pad     = head_reg.event_pad;
    assign out_ch.is_note_on    = head_reg.is_note_on;
    assign out_ch.note_number   = head_reg.note_number;
    assign out_ch.note_velocity = head_reg.note_velocity;

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry without head entry");

    a_stalled_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && head_valid_reg && !out_ch.ready) |=> skid_valid_reg)
        else $error("result lost while output stalled");

    a_active_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg & ~armed_reg) == '0)
        else $error("pad note active while not armed");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import pdtd_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
    localparam logic [VEL_W-1:0] VEL_STEPS [0:18] = '{
        7'd0, 7'd0, 7'd2, 7'd5, 7'd9, 7'd13, 7'd18, 7'd24, 7'd30, 7'd36,
        7'd43, 7'd51, 7'd59, 7'd68, 7'd77, 7'd86, 7'd96, 7'd106, 7'd117
    };

    typedef enum logic [1:0] {HIT_QUIET, HIT_RISE, HIT_FALL, HIT_DECAY} hit_stage_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pdtd_in_if  in_ch();
    pdtd_out_if out_ch();

    piezo_drum_trigger_detector_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // mirrored registers and per-pad trigger state
    logic [SAMPLE_W-1:0] cfg_threshold;
    logic [TIME_W-1:0]   cfg_holdoff;
    logic [NOTE_W-1:0]   cfg_note [PAD_COUNT];
    logic [SAMPLE_W-1:0] pad_prev [PAD_COUNT];
    bit                  pad_active [PAD_COUNT];
    bit                  pad_active_was [PAD_COUNT];
    bit                  pad_armed [PAD_COUNT];
    logic [TIME_W-1:0]   pad_holdoff_start [PAD_COUNT];
    logic [VEL_W-1:0]    pad_velocity [PAD_COUNT];

    result_t             pending_notes [$];

    // stimulus shaping
    hit_stage_t          hit_stage [PAD_COUNT];
    logic [SAMPLE_W-1:0] last_sent [PAD_COUNT];
    logic [TIME_W-1:0]   now_us;
    int unsigned         step_hi;
    bit                  idle_on;
    int                  sink_hold;

    int failures;
    int cycle_count;
    int samples_sent;
    int notes_on_seen;
    int notes_off_seen;
    int phases_run;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d events outstanding",
                   cycle_count, pending_notes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            out_ch.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_hold <= pick_gap();
        end
    end

    function automatic logic [NOTE_W-1:0] rand_note();
        return NOTE_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [VEL_W-1:0] velocity_for_peak(input logic [SAMPLE_W-1:0] peak);
        logic [SAMPLE_W-1:0] idx;
        idx = peak >> 3;
        if (idx != 0)
            idx = idx - 10'd1;
        return (idx <= 18) ? VEL_STEPS[idx] : 7'd127;
    endfunction

    function automatic bit predict_note(input logic [PAD_W-1:0] pad,
                                        input logic [SAMPLE_W-1:0] s,
                                        input logic [TIME_W-1:0] t,
                                        output result_t ev);
        logic [SAMPLE_W-1:0] prev;
        logic [TIME_W-1:0]   since_start;
        bit                  elapsed;
        bit                  fired;
        prev = pad_prev[pad];
        since_start = t - pad_holdoff_start[pad];
        elapsed = since_start >= cfg_holdoff;
        fired = 1'b0;
        ev = '0;
        if (s >= cfg_threshold && s > prev && !pad_active[pad] && !pad_armed[pad])
        begin
            pad_armed[pad] = 1'b1;
        end
        else if (prev > s && prev > cfg_threshold && !pad_active[pad] && pad_armed[pad])
        begin
            pad_active[pad] = 1'b1;
            pad_velocity[pad] = velocity_for_peak(prev);
            if (!pad_active_was[pad] && elapsed)
            begin
                ev.event_pad = pad;
                ev.is_note_on = 1'b1;
                ev.note_number = cfg_note[pad];
                ev.note_velocity = pad_velocity[pad];
                pad_holdoff_start[pad] = t;
                fired = 1'b1;
            end
        end
        else if (s < cfg_threshold && pad_active[pad] && pad_active_was[pad] && elapsed)
        begin
            pad_active[pad] = 1'b0;
            pad_armed[pad] = 1'b0;
            ev.event_pad = pad;
            ev.is_note_on = 1'b0;
            ev.note_number = cfg_note[pad];
            ev.note_velocity = pad_velocity[pad];
            fired = 1'b1;
        end
        pad_active_was[pad] = pad_active[pad];
        pad_prev[pad] = s;
        return fired;
    endfunction

    always @(posedge clk)
    begin : check_notes
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (out_ch.is_note_on)
                notes_on_seen++;
            else
                notes_off_seen++;
            if (pending_notes.size() == 0)
            begin
                $error("unexpected note event on pad %0d", out_ch.event_pad);
                failures++;
            end
            else
            begin
                want = pending_notes.pop_front();
                if (out_ch.event_pad !== want.event_pad)
                begin
                    $error("event_pad: expected %0d, got %0d",
                           want.event_pad, out_ch.event_pad);
                    failures++;
                end
                if (out_ch.is_note_on !== want.is_note_on)
                begin
                    $error("is_note_on: expected %0d, got %0d",
                           want.is_note_on, out_ch.is_note_on);
                    failures++;
                end
                if (out_ch.note_number !== want.note_number)
                begin
                    $error("note_number: expected %0d, got %0d",
                           want.note_number, out_ch.note_number);
                    failures++;
                end
                if (out_ch.note_velocity !== want.note_velocity)
                begin
                    $error("note_velocity: expected %0d, got %0d",
                           want.note_velocity, out_ch.note_velocity);
                    failures++;
                end
            end
        end
    end

    // entered just after a rising edge, returns just after the transfer edge
    task automatic send_sample(input logic [PAD_W-1:0] pad,
                               input logic [SAMPLE_W-1:0] s,
                               input logic [TIME_W-1:0] t);
        int      gap;
        result_t ev;
        gap = pick_gap();
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pad_index <= pad;
        in_ch.sample    <= s;
        in_ch.time_us   <= t;
        do
            @(posedge clk);
        while (!in_ch.ready);
        samples_sent++;
        if (predict_note(pad, s, t, ev))
            pending_notes.push_back(ev);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD: cfg_threshold = data[SAMPLE_W-1:0];
            REG_HOLDOFF:   cfg_holdoff = data[TIME_W-1:0];
            REG_NOTE_0:    cfg_note[0] = data[NOTE_W-1:0];
            REG_NOTE_1:    cfg_note[1] = data[NOTE_W-1:0];
            REG_NOTE_2:    cfg_note[2] = data[NOTE_W-1:0];
            REG_NOTE_3:    cfg_note[3] = data[NOTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [SAMPLE_W-1:0] thr, input logic [TIME_W-1:0] hold,
                                input logic [NOTE_W-1:0] n0, input logic [NOTE_W-1:0] n1,
                                input logic [NOTE_W-1:0] n2, input logic [NOTE_W-1:0] n3);
        settle();
        write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_HOLDOFF, hold);
        write_reg(REG_NOTE_0, CFG_DATA_W'(n0));
        write_reg(REG_NOTE_1, CFG_DATA_W'(n1));
        write_reg(REG_NOTE_2, CFG_DATA_W'(n2));
        write_reg(REG_NOTE_3, CFG_DATA_W'(n3));
        end_writes();
        phases_run++;
    endtask

    function automatic logic [SAMPLE_W-1:0] below_threshold();
        if (cfg_threshold == 0)
            return '0;
        return SAMPLE_W'($urandom_range(0, cfg_threshold - 1));
    endfunction

    // strike-shaped sample stream per pad, with some noise mixed in
    function automatic logic [SAMPLE_W-1:0] next_sample(input logic [PAD_W-1:0] pad);
        logic [SAMPLE_W-1:0] s;
        int                  lo;
        int                  hi;
        if ($urandom_range(0, 99) < 12)
        begin
            s = SAMPLE_W'($urandom_range(0, 1023));
        end
        else
        begin
            case (hit_stage[pad])
                HIT_QUIET:
                begin
                    s = below_threshold();
                    hit_stage[pad] = HIT_RISE;
                end
                HIT_RISE:
                begin
                    lo = (int'(last_sent[pad]) + 1 > int'(cfg_threshold)) ?
                         int'(last_sent[pad]) + 1 : int'(cfg_threshold);
                    if (lo > 1023)
                    begin
                        s = 10'd1023;
                        hit_stage[pad] = HIT_FALL;
                    end
                    else
                    begin
                        hi = ($urandom_range(0, 1) == 0) ? ((lo + 40 > 1023) ? 1023 : lo + 40)
                                                          : 1023;
                        s = SAMPLE_W'($urandom_range(lo, hi));
                        if ($urandom_range(0, 9) >= 3)
                            hit_stage[pad] = HIT_FALL;
                    end
                end
                HIT_FALL:
                begin
                    s = (last_sent[pad] == 0) ? '0
                        : SAMPLE_W'($urandom_range(0, last_sent[pad] - 10'd1));
                    hit_stage[pad] = HIT_DECAY;
                end
                default:
                begin
                    s = below_threshold();
                    if ($urandom_range(0, 9) >= 4)
                        hit_stage[pad] = HIT_RISE;
                end
            endcase
        end
        last_sent[pad] = s;
        return s;
    endfunction

    function automatic logic [TIME_W-1:0] next_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            now_us = now_us + $urandom_range(0, step_hi);
        else if (r < 97)
            now_us = now_us + $urandom_range(0, 4 * step_hi);
        else
            now_us = $urandom;
        return now_us;
    endfunction

    task automatic run_random_traffic(input int unsigned step, input logic [TIME_W-1:0] t0,
                                      input int count, input bit gaps, input bit pause_midway);
        logic [PAD_W-1:0] pad;
        step_hi = step;
        now_us = t0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                idle_on = gaps && ($urandom_range(0, 3) != 0);
            if (pause_midway && i == count / 2)
                settle();
            pad = PAD_W'($urandom_range(0, PAD_COUNT - 1));
            send_sample(pad, next_sample(pad), next_time());
        end
    endtask

    task automatic test_default_strike();
        send_sample(2'd0, 10'd0, 32'd0);
        send_sample(2'd0, 10'd700, 32'd10);
        send_sample(2'd0, 10'd900, 32'd20);
        send_sample(2'd0, 10'd800, 32'd30000);
        send_sample(2'd0, 10'd1023, 32'd30001);
        send_sample(2'd0, 10'd100, 32'd40000);
        send_sample(2'd0, 10'd100, 32'd52730);
    endtask

    task automatic test_suppressed_note_on();
        send_sample(2'd1, 10'd700, 32'd100);
        send_sample(2'd1, 10'd650, 32'd200);
        send_sample(2'd1, 10'd100, 32'd300);
        send_sample(2'd1, 10'd100, 32'd23000);
    endtask

    task automatic test_low_peak_velocity();
        apply_config(10'd3, 32'd0, 7'd51, 7'd50, 7'd52, 7'd53);
        send_sample(2'd2, 10'd5, 32'd1);
        send_sample(2'd2, 10'd2, 32'd2);
        send_sample(2'd2, 10'd1, 32'd3);
        send_sample(2'd3, 10'd159, 32'd4);
        send_sample(2'd3, 10'd50, 32'd5);
        send_sample(2'd3, 10'd0, 32'd6);
    endtask

    task automatic test_unknown_register();
        settle();
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        end_writes();
    endtask

    task automatic test_holdoff_wrap();
        apply_config(10'd600, 32'hFFFF_FFFF, 7'd0, 7'd127, 7'd0, 7'd127);
        send_sample(2'd0, 10'd700, 32'd1000);
        send_sample(2'd0, 10'd650, 32'd29999);
        send_sample(2'd0, 10'd100, 32'd29998);
        apply_config(10'd600, 32'd100, 7'd127, 7'd0, 7'd127, 7'd0);
        send_sample(2'd1, 10'd800, 32'hFFFF_FFC0);
        send_sample(2'd1, 10'd700, 32'hFFFF_FFFF);
        send_sample(2'd1, 10'd50, 32'h0000_0010);
        send_sample(2'd1, 10'd50, 32'h0000_0070);
    endtask

    task automatic test_random_default_config();
        apply_config(10'd600, 32'd22730, 7'd51, 7'd50, 7'd52, 7'd53);
        run_random_traffic(15000, $urandom, 300, 1'b1, 1'b0);
    endtask

    task automatic test_random_velocity_curve();
        apply_config(10'd100, 32'd50, rand_note(), rand_note(), rand_note(), rand_note());
        run_random_traffic(40, $urandom, 300, 1'b1, 1'b0);
    endtask

    task automatic test_random_back_to_back();
        apply_config(10'd0, 32'd0, 7'd127, 7'd127, 7'd0, 7'd0);
        run_random_traffic(10, $urandom, 150, 1'b0, 1'b0);
    endtask

    task automatic test_random_unreachable_threshold();
        apply_config(10'd1023, 32'd200, rand_note(), rand_note(), rand_note(), rand_note());
        run_random_traffic(150, $urandom, 100, 1'b1, 1'b0);
    endtask

    task automatic test_random_max_holdoff();
        apply_config(10'd20, 32'hFFFF_FFFF, rand_note(), rand_note(), rand_note(),
                     rand_note());
        run_random_traffic(100000, $urandom, 100, 1'b1, 1'b0);
    endtask

    task automatic test_random_time_wrap();
        apply_config(10'd60, 32'd10, rand_note(), rand_note(), rand_note(), rand_note());
        run_random_traffic(30, 32'hFFFF_F000, 400, 1'b1, 1'b1);
    endtask

    task automatic test_random_mixed_config();
        logic [TIME_W-1:0] hold;
        for (int k = 0; k < 4; k++)
        begin
            hold = $urandom_range(0, 300);
            apply_config(SAMPLE_W'($urandom_range(0, 200)), hold, rand_note(),
                         rand_note(), rand_note(), rand_note());
            run_random_traffic(hold + 1, $urandom, 100, 1'b1, 1'b0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.pad_index = '0;
        in_ch.sample = '0;
        in_ch.time_us = '0;
        out_ch.ready = 1'b0;
        sink_hold = 0;
        idle_on = 1'b1;
        now_us = '0;
        step_hi = 0;

        cfg_threshold = THRESHOLD_RST;
        cfg_holdoff = HOLDOFF_RST;
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            cfg_note[p] = NOTE_RST[p];
            pad_prev[p] = '0;
            pad_active[p] = 1'b0;
            pad_active_was[p] = 1'b0;
            pad_armed[p] = 1'b0;
            pad_holdoff_start[p] = '0;
            pad_velocity[p] = '0;
            hit_stage[p] = HIT_QUIET;
            last_sent[p] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_strike();
        test_suppressed_note_on();
        test_low_peak_velocity();
        test_unknown_register();
        test_holdoff_wrap();
        test_random_default_config();
        test_random_velocity_curve();
        test_random_back_to_back();
        test_random_unreachable_threshold();
        test_random_max_holdoff();
        test_random_time_wrap();
        test_random_mixed_config();
        settle();

        $display("Ran %0d samples over %0d register settings in %0d cycles.",
                 samples_sent, phases_run, cycle_count);
        $display("Checked %0d note-on and %0d note-off events.",
                 notes_on_seen, notes_off_seen);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
